@@ rtl/ggce_pkg.sv @@
// Shared types, constants and gate function for the gate grid circuit evaluator.
package ggce_pkg;

  // Default grid limits
  localparam int unsigned MAX_ROW_COUNT = 16;
  localparam int unsigned MAX_COL_COUNT = 16;

  // Field and register widths
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned GATE_CFG_W = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned GENE_IDX_W = 10;
  localparam int unsigned GENE_VAL_W = 8;
  localparam int unsigned TT_W       = 16;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned REM_W      = 5;
  localparam int unsigned GATE_W     = 3;
  localparam int unsigned QUO_W      = GENE_IDX_W - 1;

  // Largest gate modulus
  localparam logic [GATE_CFG_W-1:0] MAX_GATES = GATE_CFG_W'(8);

  // Register reset values
  localparam logic [CFG_W-1:0]      ROW_COUNT_RST    = CFG_W'(16);
  localparam logic [CFG_W-1:0]      COL_COUNT_RST    = CFG_W'(16);
  localparam logic [CFG_W-1:0]      INPUT_COUNT_RST  = CFG_W'(4);
  localparam logic [GATE_CFG_W-1:0] GATE_COUNT_RST   = GATE_CFG_W'(5);
  localparam logic [CFG_W-1:0]      OUTPUT_COUNT_RST = CFG_W'(3);

  // Divide by three as multiply by reciprocal: (x * 683) >> 11, exact for 10-bit x
  localparam int unsigned RECIP_3     = 683;
  localparam int unsigned RECIP_SHIFT = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT    = 3'd0,
    CFG_COL_COUNT    = 3'd1,
    CFG_INPUT_COUNT  = 3'd2,
    CFG_GATE_COUNT   = 3'd3,
    CFG_OUTPUT_COUNT = 3'd4
  } cfg_idx_e;

  typedef enum logic [GATE_W-1:0] {
    GATE_AND   = 3'd0,
    GATE_OR    = 3'd1,
    GATE_NOT   = 3'd2,
    GATE_WIRE  = 3'd3,
    GATE_XOR   = 3'd4,
    GATE_NOT1  = 3'd5,
    GATE_WIRE1 = 3'd6,
    GATE_XOR1  = 3'd7
  } gate_e;

  // Which gene of a cell a load writes
  typedef enum logic [1:0] {
    FLD_FIRST  = 2'd0,
    FLD_SECOND = 2'd1,
    FLD_GATE   = 2'd2
  } field_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_LOAD_CHK  = 3'd1,
    ST_LOAD_MOD  = 3'd2,
    ST_EVAL_INIT = 3'd3,
    ST_EVAL_COL  = 3'd4,
    ST_RESULT    = 3'd5
  } state_e;

  // Remainder unit request and response
  typedef struct packed {
    logic                  start;
    logic [GENE_VAL_W-1:0] dividend;
    logic [REM_W-1:0]      divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } mod_rsp_t;

  // One logic cell
  function automatic logic gate_eval(input gate_e g, input logic a, input logic b);
    logic y;
    case (g)
      GATE_AND:   y = a & b;
      GATE_OR:    y = a | b;
      GATE_NOT:   y = ~a;
      GATE_NOT1:  y = ~a;
      GATE_WIRE:  y = a;
      GATE_WIRE1: y = a;
      GATE_XOR:   y = a ^ b;
      GATE_XOR1:  y = a ^ b;
      default:    y = a ^ b;
    endcase
    return y;
  endfunction

endpackage

@@ rtl/ggce_mod_unit.sv @@
// Bit-serial remainder unit: gene value mod a small divisor, one bit per cycle.
module ggce_mod_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ggce_pkg::mod_req_t  req_i,
  output ggce_pkg::mod_rsp_t  rsp_o
);

  localparam int unsigned DW = ggce_pkg::GENE_VAL_W;
  localparam int unsigned RW = ggce_pkg::REM_W;
  localparam logic [3:0]  STEPS = 4'(DW);

  logic          busy_q;
  logic [3:0]    cnt_q;
  logic [DW-1:0] dvd_q;
  logic [RW-1:0] div_q;
  logic [RW-1:0] rem_q;

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic [RW-1:0] rem_step;

  // Restoring step: shift in next dividend bit, subtract divisor if it fits
  always_comb begin
    trial    = {rem_q, dvd_q[DW-1]};
    diff     = trial - {1'b0, div_q};
    rem_step = (trial >= {1'b0, div_q}) ? diff[RW-1:0] : trial[RW-1:0];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= STEPS;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 4'd1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      rem_q <= rem_step;
    end
  end

  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/ggce_cell_store.sv @@
// Banked cell memory: one write per cycle, one full column read per cycle.
module ggce_cell_store #(
  parameter int unsigned MAX_ROW_COUNT = ggce_pkg::MAX_ROW_COUNT,
  parameter int unsigned MAX_COL_COUNT = ggce_pkg::MAX_COL_COUNT
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  ggce_pkg::field_e                      wr_field_i,
  input  logic [$clog2(MAX_ROW_COUNT*MAX_COL_COUNT)-1:0] wr_cell_i,
  input  logic [ggce_pkg::REM_W-1:0]            wr_data_i,
  input  logic [$clog2(MAX_ROW_COUNT*MAX_COL_COUNT+1)-1:0] rd_start_i,
  output logic [(1<<$clog2(MAX_ROW_COUNT))-1:0][$clog2(MAX_ROW_COUNT)-1:0] rd_first_o,
  output logic [(1<<$clog2(MAX_ROW_COUNT))-1:0][$clog2(MAX_ROW_COUNT)-1:0] rd_second_o,
  output logic [(1<<$clog2(MAX_ROW_COUNT))-1:0][ggce_pkg::GATE_W-1:0]      rd_gate_o,
  output logic [$clog2(MAX_ROW_COUNT)-1:0]      rd_rot_o
);

  localparam int unsigned DEPTH   = MAX_ROW_COUNT * MAX_COL_COUNT;
  localparam int unsigned BANK_W  = $clog2(MAX_ROW_COUNT);
  localparam int unsigned SEL_W   = BANK_W;
  localparam int unsigned NB      = 1 << BANK_W;
  localparam int unsigned BD      = (DEPTH + NB - 1) / NB;
  localparam int unsigned BA_W    = (BD > 1) ? $clog2(BD) : 1;
  localparam int unsigned ENTRIES = 1 << BA_W;
  localparam int unsigned GW      = ggce_pkg::GATE_W;

  // Cell n lives in bank n mod NB at address n / NB
  logic [BANK_W-1:0] wr_bank;
  logic [BA_W-1:0]   wr_addr;
  logic [BANK_W-1:0] rd_off;
  logic [BA_W-1:0]   rd_base;

  assign wr_bank = wr_cell_i[BANK_W-1:0];
  assign wr_addr = BA_W'(wr_cell_i >> BANK_W);
  assign rd_off  = rd_start_i[BANK_W-1:0];
  assign rd_base = BA_W'(rd_start_i >> BANK_W);

  // Rotation that brings row 0 of the column to lane 0
  always_ff @(posedge clk_i) begin
    rd_rot_o <= rd_off;
  end

  for (genvar b = 0; b < NB; b++) begin : g_bank
    localparam logic [BANK_W-1:0] BANK_ID = BANK_W'(b);

    logic [SEL_W-1:0] first_mem  [ENTRIES];
    logic [SEL_W-1:0] second_mem [ENTRIES];
    logic [GW-1:0]    gate_mem   [ENTRIES];
    logic             wr_hit;
    logic [BA_W-1:0]  rd_addr;

    assign wr_hit  = wr_en_i && (wr_bank == BANK_ID);
    // Banks below the start offset hold the wrapped part of the column
    assign rd_addr = (BANK_ID < rd_off) ? BA_W'(rd_base + 1'b1) : rd_base;

    always_ff @(posedge clk_i) begin
      if (wr_hit && (wr_field_i == ggce_pkg::FLD_FIRST)) begin
        first_mem[wr_addr] <= SEL_W'(wr_data_i);
      end
      if (wr_hit && (wr_field_i == ggce_pkg::FLD_SECOND)) begin
        second_mem[wr_addr] <= SEL_W'(wr_data_i);
      end
      if (wr_hit && (wr_field_i == ggce_pkg::FLD_GATE)) begin
        gate_mem[wr_addr] <= wr_data_i[GW-1:0];
      end
      rd_first_o[b]  <= first_mem[rd_addr];
      rd_second_o[b] <= second_mem[rd_addr];
      rd_gate_o[b]   <= gate_mem[rd_addr];
    end
  end

endmodule

@@ rtl/ggce_col_eval.sv @@
// One column of gate lanes: routes stored cells to lanes and evaluates them.
module ggce_col_eval #(
  parameter int unsigned MAX_ROW_COUNT = ggce_pkg::MAX_ROW_COUNT
) (
  input  logic [MAX_ROW_COUNT-1:0]             sig_i,
  input  logic [ggce_pkg::CFG_W-1:0]           rows_i,
  input  logic [$clog2(MAX_ROW_COUNT)-1:0]     rot_i,
  input  logic [(1<<$clog2(MAX_ROW_COUNT))-1:0][$clog2(MAX_ROW_COUNT)-1:0] first_i,
  input  logic [(1<<$clog2(MAX_ROW_COUNT))-1:0][$clog2(MAX_ROW_COUNT)-1:0] second_i,
  input  logic [(1<<$clog2(MAX_ROW_COUNT))-1:0][ggce_pkg::GATE_W-1:0]      gate_i,
  output logic [MAX_ROW_COUNT-1:0]             nxt_o
);

  localparam int unsigned BANK_W = $clog2(MAX_ROW_COUNT);
  localparam int unsigned SEL_W  = BANK_W;
  localparam int unsigned NB     = 1 << BANK_W;
  localparam int unsigned CMP_W  = (SEL_W > ggce_pkg::CFG_W) ? SEL_W : ggce_pkg::CFG_W;

  logic [NB-1:0] sig_pad;
  assign sig_pad = NB'(sig_i);

  for (genvar k = 0; k < MAX_ROW_COUNT; k++) begin : g_lane
    logic [BANK_W-1:0] bank;
    logic [SEL_W-1:0]  fsel;
    logic [SEL_W-1:0]  ssel;
    logic              a;
    logic              b;

    assign bank = BANK_W'(rot_i + BANK_W'(k));
    assign fsel = first_i[bank];
    assign ssel = second_i[bank];
    // Selectors past the rows in use read a zero signal
    assign a = (CMP_W'(fsel) < CMP_W'(rows_i)) ? sig_pad[fsel] : 1'b0;
    assign b = (CMP_W'(ssel) < CMP_W'(rows_i)) ? sig_pad[ssel] : 1'b0;
    assign nxt_o[k] = ggce_pkg::gate_eval(ggce_pkg::gate_e'(gate_i[bank]), a, b);
  end

endmodule

@@ rtl/gate_grid_circuit_evaluator.sv @@
// Top level: sequencer, configuration registers, signal register and result register.
//
// A load request passes through a range check and the divide-by-three split of the
// gene index, then the bit-serial remainder unit (gene value mod rows or gates), which
// writes the banked cell memory when it finishes, then hands the result to the output
// register and returns to idle before the next request can be taken. A load whose
// gene index lies beyond the grid skips the remainder unit. For an evaluate request
// the inputs are spread over the rows by doubling, then the column lane array
// evaluates one column per cycle while the banked memory reads the next column into
// its registered outputs. A finished result sits in an output register, so a new
// request is accepted while the previous result is stalled. Every cell used by an
// evaluation must have been loaded since reset.
module gate_grid_circuit_evaluator #(
  parameter int unsigned MAX_ROW_COUNT = ggce_pkg::MAX_ROW_COUNT,
  parameter int unsigned MAX_COL_COUNT = ggce_pkg::MAX_COL_COUNT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [ggce_pkg::GENE_IDX_W-1:0]     gene_index_i,
  input  logic [ggce_pkg::GENE_VAL_W-1:0]     gene_value_i,
  input  logic [ggce_pkg::TT_W-1:0]           tt_row_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ggce_pkg::OUT_W-1:0]          out_bits_o,
  output logic                                was_eval_o,
  output logic                                bad_index_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ggce_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ggce_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int unsigned CW      = ggce_pkg::CFG_W;
  localparam int unsigned GCW     = ggce_pkg::GATE_CFG_W;
  localparam int unsigned IW      = ggce_pkg::GENE_IDX_W;
  localparam int unsigned VW      = ggce_pkg::GENE_VAL_W;
  localparam int unsigned OW      = ggce_pkg::OUT_W;
  localparam int unsigned QW      = ggce_pkg::QUO_W;
  localparam int unsigned LANES   = MAX_ROW_COUNT;
  localparam int unsigned DEPTH   = MAX_ROW_COUNT * MAX_COL_COUNT;
  localparam int unsigned CELL_W  = $clog2(DEPTH);
  localparam int unsigned START_W = $clog2(DEPTH + 1);
  localparam int unsigned BANK_W  = $clog2(MAX_ROW_COUNT);
  localparam int unsigned SEL_W   = BANK_W;
  localparam int unsigned NB      = 1 << BANK_W;
  localparam int unsigned LEN_W   = CW + 1;
  localparam int unsigned AREA_W  = 2 * CW;
  localparam int unsigned LIM_W   = AREA_W + 2;
  localparam int unsigned PROD_W  = 2 * IW;
  localparam logic [CW-1:0] ROW_CAP = (MAX_ROW_COUNT > 31) ? CW'(31) : CW'(MAX_ROW_COUNT);
  localparam logic [CW-1:0] COL_CAP = (MAX_COL_COUNT > 31) ? CW'(31) : CW'(MAX_COL_COUNT);
  localparam logic [CW-1:0] OUT_CAP = CW'(OW);
  localparam logic [CW-1:0] ONE     = CW'(1);

  // ---------------- configuration registers ----------------
  logic [CW-1:0]  row_cnt_q, col_cnt_q, in_cnt_q, out_cnt_q;
  logic [GCW-1:0] gate_cnt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q  <= ggce_pkg::ROW_COUNT_RST;
      col_cnt_q  <= ggce_pkg::COL_COUNT_RST;
      in_cnt_q   <= ggce_pkg::INPUT_COUNT_RST;
      gate_cnt_q <= ggce_pkg::GATE_COUNT_RST;
      out_cnt_q  <= ggce_pkg::OUTPUT_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ggce_pkg::cfg_idx_e'(cfg_index_i))
        ggce_pkg::CFG_ROW_COUNT:    row_cnt_q  <= cfg_data_i;
        ggce_pkg::CFG_COL_COUNT:    col_cnt_q  <= cfg_data_i;
        ggce_pkg::CFG_INPUT_COUNT:  in_cnt_q   <= cfg_data_i;
        ggce_pkg::CFG_GATE_COUNT:   gate_cnt_q <= cfg_data_i[GCW-1:0];
        ggce_pkg::CFG_OUTPUT_COUNT: out_cnt_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective counts after clamping
  logic [CW-1:0]  rows, cols, ins, outs, outs_row;
  logic [GCW-1:0] gates;

  always_comb begin
    rows     = (row_cnt_q == '0) ? ONE : ((row_cnt_q > ROW_CAP) ? ROW_CAP : row_cnt_q);
    cols     = (col_cnt_q == '0) ? ONE : ((col_cnt_q > COL_CAP) ? COL_CAP : col_cnt_q);
    ins      = (in_cnt_q == '0) ? ONE : ((in_cnt_q > rows) ? rows : in_cnt_q);
    gates    = (gate_cnt_q == '0) ? GCW'(1) :
               ((gate_cnt_q > ggce_pkg::MAX_GATES) ? ggce_pkg::MAX_GATES : gate_cnt_q);
    outs_row = (out_cnt_q > rows) ? rows : out_cnt_q;
    outs     = (outs_row > OUT_CAP) ? OUT_CAP : outs_row;
  end

  // ---------------- state and datapath registers ----------------
  ggce_pkg::state_e state_q, state_d;
  ggce_pkg::field_e field_q, field_d;

  logic [IW-1:0]      idx_q, idx_d;
  logic [VW-1:0]      val_q, val_d;
  logic [CELL_W-1:0]  cell_q, cell_d;
  logic [LANES-1:0]   sig_q, sig_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [START_W-1:0] start_q, start_d;
  logic [CW-1:0]      iss_q, iss_d;
  logic [CW-1:0]      cmp_q, cmp_d;
  logic               rd_vld_q, rd_vld_d;
  logic [OW-1:0]      res_bits_q, res_bits_d;
  logic               res_eval_q, res_eval_d;
  logic               res_bad_q, res_bad_d;
  logic               out_vld_q, out_vld_d;
  logic [OW-1:0]      out_bits_q, out_bits_d;
  logic               out_eval_q, out_eval_d;
  logic               out_bad_q, out_bad_d;

  logic in_acc;
  logic out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != ggce_pkg::ST_IDLE);

  // ---------------- load address decode ----------------
  logic [AREA_W-1:0] area;
  logic [LIM_W-1:0]  lim;
  logic              bad;
  logic [PROD_W-1:0] qprod;
  logic [QW-1:0]     quo;
  logic [IW-1:0]     three_q;
  logic [IW-1:0]     fld;

  always_comb begin
    area    = AREA_W'(rows) * AREA_W'(cols);
    lim     = LIM_W'(area) + {1'b0, area, 1'b0};
    bad     = (LIM_W'(idx_q) >= lim);
    qprod   = PROD_W'(idx_q) * PROD_W'(ggce_pkg::RECIP_3);
    quo     = qprod[ggce_pkg::RECIP_SHIFT +: QW];
    three_q = {quo, 1'b0} + IW'(quo);
    fld     = idx_q - three_q;
  end

  // ---------------- remainder unit ----------------
  ggce_pkg::mod_req_t mod_req;
  ggce_pkg::mod_rsp_t mod_rsp;

  always_comb begin
    mod_req.start    = (state_q == ggce_pkg::ST_LOAD_CHK) && !bad;
    mod_req.dividend = val_q;
    mod_req.divisor  = (ggce_pkg::field_e'(fld[1:0]) == ggce_pkg::FLD_GATE) ?
                       CW'(gates) : rows;
  end

  ggce_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // ---------------- cell store ----------------
  logic                               wr_en;
  logic [NB-1:0][SEL_W-1:0]           rd_first, rd_second;
  logic [NB-1:0][ggce_pkg::GATE_W-1:0] rd_gate;
  logic [BANK_W-1:0]                  rd_rot;

  assign wr_en = (state_q == ggce_pkg::ST_LOAD_MOD) && mod_rsp.done;

  ggce_cell_store #(
    .MAX_ROW_COUNT (MAX_ROW_COUNT),
    .MAX_COL_COUNT (MAX_COL_COUNT)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_field_i  (field_q),
    .wr_cell_i   (cell_q),
    .wr_data_i   (mod_rsp.rem),
    .rd_start_i  (start_q),
    .rd_first_o  (rd_first),
    .rd_second_o (rd_second),
    .rd_gate_o   (rd_gate),
    .rd_rot_o    (rd_rot)
  );

  // ---------------- column lanes ----------------
  logic [LANES-1:0] col_nxt;

  ggce_col_eval #(
    .MAX_ROW_COUNT (MAX_ROW_COUNT)
  ) u_col (
    .sig_i    (sig_q),
    .rows_i   (rows),
    .rot_i    (rd_rot),
    .first_i  (rd_first),
    .second_i (rd_second),
    .gate_i   (rd_gate),
    .nxt_o    (col_nxt)
  );

  // Primary inputs placed on the first input_count rows
  logic [LANES-1:0] tt_ext, tt_masked;
  assign tt_ext = LANES'(tt_row_i);

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      tt_masked[j] = (int'(ins) > j) ? tt_ext[j] : 1'b0;
    end
  end

  // Reported bits of the last column
  logic [OW-1:0] col_pad, col_bits;
  assign col_pad = OW'(col_nxt);

  always_comb begin
    for (int i = 0; i < OW; i++) begin
      col_bits[i] = (int'(outs) > i) ? col_pad[i] : 1'b0;
    end
  end

  logic spread_done;
  logic col_issue;
  logic col_last;
  assign spread_done = (len_q >= LEN_W'(rows));
  assign col_issue   = (iss_q < cols);
  assign col_last    = rd_vld_q && (CW'(cmp_q + ONE) == cols);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ggce_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = kind_i ? ggce_pkg::ST_EVAL_INIT : ggce_pkg::ST_LOAD_CHK;
        end
      end
      ggce_pkg::ST_LOAD_CHK: begin
        state_d = bad ? ggce_pkg::ST_RESULT : ggce_pkg::ST_LOAD_MOD;
      end
      ggce_pkg::ST_LOAD_MOD: begin
        if (mod_rsp.done) state_d = ggce_pkg::ST_RESULT;
      end
      ggce_pkg::ST_EVAL_INIT: begin
        if (spread_done) state_d = ggce_pkg::ST_EVAL_COL;
      end
      ggce_pkg::ST_EVAL_COL: begin
        if (col_last) state_d = ggce_pkg::ST_RESULT;
      end
      ggce_pkg::ST_RESULT: begin
        if (out_free) state_d = ggce_pkg::ST_IDLE;
      end
      default: state_d = ggce_pkg::ST_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_comb begin
    idx_d      = idx_q;
    val_d      = val_q;
    cell_d     = cell_q;
    field_d    = field_q;
    sig_d      = sig_q;
    len_d      = len_q;
    start_d    = start_q;
    iss_d      = iss_q;
    cmp_d      = cmp_q;
    rd_vld_d   = 1'b0;
    res_bits_d = res_bits_q;
    res_eval_d = res_eval_q;
    res_bad_d  = res_bad_q;
    // result register empties when taken
    out_vld_d  = out_vld_q && out_stall_i;
    out_bits_d = out_bits_q;
    out_eval_d = out_eval_q;
    out_bad_d  = out_bad_q;

    case (state_q)
      ggce_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_d   = gene_index_i;
          val_d   = gene_value_i;
          sig_d   = tt_masked;
          len_d   = LEN_W'(ins);
          start_d = '0;
          iss_d   = '0;
          cmp_d   = '0;
        end
      end
      ggce_pkg::ST_LOAD_CHK: begin
        cell_d     = CELL_W'(quo);
        field_d    = ggce_pkg::field_e'(fld[1:0]);
        res_bits_d = '0;
        res_eval_d = 1'b0;
        res_bad_d  = bad;
      end
      ggce_pkg::ST_EVAL_INIT: begin
        // double the repeated input pattern until it covers all rows
        if (!spread_done) begin
          sig_d = sig_q | (sig_q << len_q);
          len_d = {len_q[LEN_W-2:0], 1'b0};
        end
      end
      ggce_pkg::ST_EVAL_COL: begin
        if (col_issue) begin
          start_d  = START_W'(start_q + START_W'(rows));
          iss_d    = iss_q + ONE;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          sig_d      = col_nxt;
          cmp_d      = cmp_q + ONE;
          res_bits_d = col_bits;
          res_eval_d = 1'b1;
          res_bad_d  = 1'b0;
        end
      end
      ggce_pkg::ST_RESULT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_bits_d = res_bits_q;
          out_eval_d = res_eval_q;
          out_bad_d  = res_bad_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ggce_pkg::ST_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      iss_q     <= '0;
      cmp_q     <= '0;
      len_q     <= '0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      iss_q     <= iss_d;
      cmp_q     <= cmp_d;
      len_q     <= len_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    val_q      <= val_d;
    cell_q     <= cell_d;
    field_q    <= field_d;
    sig_q      <= sig_d;
    start_q    <= start_d;
    res_bits_q <= res_bits_d;
    res_eval_q <= res_eval_d;
    res_bad_q  <= res_bad_d;
    out_bits_q <= out_bits_d;
    out_eval_q <= out_eval_d;
    out_bad_q  <= out_bad_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_bits_o  = out_bits_q;
  assign was_eval_o  = out_eval_q;
  assign bad_index_o = out_bad_q;

  // ---------------- assertions ----------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request accepted but block not busy next cycle");

  a_mod_done_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == ggce_pkg::ST_LOAD_MOD))
    else $error("remainder finished outside a load");

  a_load_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !was_eval_o) |-> (out_bits_o == '0))
    else $error("load result carries output bits");

  a_eval_not_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && was_eval_o) |-> !bad_index_o)
    else $error("evaluate result flagged as bad index");

endmodule
